// ----- rtl/ple_pkg.sv -----
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types, codes and defaults for the positional list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_W    = 32;
	localparam int POS_W     = 8;
	localparam int QDEPTH    = 2;
	localparam int QAW       = 1;

	// action codes on the command word
	localparam logic [2:0] ACT_INS_FRONT = 3'd0;
	localparam logic [2:0] ACT_INS_POS   = 3'd1;
	localparam logic [2:0] ACT_INS_END   = 3'd2;
	localparam logic [2:0] ACT_DELETE    = 3'd3;
	localparam logic [2:0] ACT_DUMP      = 3'd4;

	// status codes on the result word
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_RANGE = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;
	localparam logic [1:0] STAT_EMPTY = 2'd3;

	typedef enum logic [2:0] {
		OP_INS_FRONT,
		OP_INS_POS,
		OP_INS_END,
		OP_DEL,
		OP_DUMP,
		OP_BAD
	} op_t;

	typedef enum logic {
		BK_EXEC,
		BK_DUMP
	} bk_state_t;

	typedef struct packed {
		logic [2:0]               action;
		logic signed [DATA_W-1:0] value;
		logic [POS_W-1:0]         position;
	} cmd_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] item_value;
		logic [POS_W-1:0]         item_index;
		logic [POS_W-1:0]         length;
		logic                     last;
	} res_t;

	typedef struct packed {
		op_t                      op;
		logic signed [DATA_W-1:0] value;
		logic [POS_W-1:0]         position;
	} q_item_t;

	typedef struct packed {
		logic    valid;
		q_item_t item;
	} push_t;

endpackage

`default_nettype wire

// ----- rtl/positional_list_engine_top.sv -----
// ----------------------------------------------------------------------------
// positional_list_engine_top
// Ordered list of up to DEPTH signed words with insert, delete and dump.
// ----------------------------------------------------------------------------
// a command is written into the queue first; the back end then registers its result and strobe
// throughput: one insert or delete per cycle while no dump holds the back end
// a dump holds the back end until its last entry is out; busy rises when the two-word queue fills
// results cannot be stalled by the receiver
// reset empties the list and the queue; cell contents are not cleared
`default_nettype none

module positional_list_engine_top #(
	parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             start,
	output logic            busy,
	input  ple_pkg::cmd_t   cmd,
	output logic            strobe,
	output ple_pkg::res_t   result
);

	ple_pkg::push_t   push;
	ple_pkg::q_item_t head;
	logic             q_empty;
	logic             q_full;
	logic             pop;

	ple_front u_front (
		.start  (start),
		.cmd    (cmd),
		.q_full (q_full),
		.busy   (busy),
		.push   (push)
	);

	ple_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.empty  (q_empty),
		.full   (q_full)
	);

	ple_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (q_empty),
		.pop    (pop),
		.strobe (strobe),
		.result (result)
	);

endmodule

`default_nettype wire

// ----- rtl/ple_front.sv -----
// ----------------------------------------------------------------------------
// ple_front
// Takes command words and classifies the action into an operation code.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_front (
	input  wire              start,
	input  ple_pkg::cmd_t    cmd,
	input  wire              q_full,
	output logic             busy,
	output ple_pkg::push_t   push
);

	ple_pkg::op_t op;

	always_comb begin
		case (cmd.action)
			ple_pkg::ACT_INS_FRONT: op = ple_pkg::OP_INS_FRONT;
			ple_pkg::ACT_INS_POS:   op = ple_pkg::OP_INS_POS;
			ple_pkg::ACT_INS_END:   op = ple_pkg::OP_INS_END;
			ple_pkg::ACT_DELETE:    op = ple_pkg::OP_DEL;
			ple_pkg::ACT_DUMP:      op = ple_pkg::OP_DUMP;
			default:                op = ple_pkg::OP_BAD;
		endcase
	end

	assign busy               = q_full;
	assign push.valid         = start & ~q_full;
	assign push.item.op       = op;
	assign push.item.value    = cmd.value;
	assign push.item.position = cmd.position;

endmodule

`default_nettype wire

// ----- rtl/ple_queue.sv -----
// ----------------------------------------------------------------------------
// ple_queue
// Two-word queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_queue (
	input  wire               clk,
	input  wire               arst_n,
	input  ple_pkg::push_t    push,
	input  wire               pop,
	output ple_pkg::q_item_t  head,
	output logic              empty,
	output logic              full
);

	ple_pkg::q_item_t mem_q [ple_pkg::QDEPTH];
	logic [ple_pkg::QAW-1:0] wr_ptr_q;
	logic [ple_pkg::QAW-1:0] rd_ptr_q;
	logic [ple_pkg::QAW:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (ple_pkg::QAW+1)'(ple_pkg::QDEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push.valid, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/ple_back.sv -----
// ----------------------------------------------------------------------------
// ple_back
// Cell chain holding the list; executes inserts, deletes and dumps.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_back #(
	parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  ple_pkg::q_item_t  head,
	input  wire               empty,
	output logic              pop,
	output logic              strobe,
	output ple_pkg::res_t     result
);

	localparam int CW = $clog2(DEPTH + 1);

	ple_pkg::bk_state_t state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] idx_q, idx_d;
	logic signed [ple_pkg::DATA_W-1:0] cell_q [DEPTH];
	logic signed [ple_pkg::DATA_W-1:0] cell_d [DEPTH];
	logic signed [ple_pkg::DATA_W-1:0] up_w [DEPTH];
	logic signed [ple_pkg::DATA_W-1:0] dn_w [DEPTH];
	logic [ple_pkg::POS_W-1:0] ins_pos;
	logic do_ins, do_del, do_rot;
	logic strobe_d;
	ple_pkg::res_t res_d;
	logic full_w;

	// neighbor taps of the cell chain
	for (genvar g = 0; g < DEPTH; g++) begin : g_tap
		if (g == DEPTH - 1) begin : g_top
			assign up_w[g] = cell_q[g];
		end else begin : g_mid
			assign up_w[g] = cell_q[g+1];
		end
		if (g == 0) begin : g_bot
			assign dn_w[g] = head.value;
		end else begin : g_rest
			assign dn_w[g] = cell_q[g-1];
		end
	end

	assign full_w = (cnt_q == CW'(DEPTH));

	always_comb begin
		case (head.op)
			ple_pkg::OP_INS_FRONT: ins_pos = '0;
			ple_pkg::OP_INS_END:   ins_pos = ple_pkg::POS_W'(cnt_q);
			default:               ins_pos = head.position;
		endcase
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		idx_d    = idx_q;
		pop      = 1'b0;
		strobe_d = 1'b0;
		do_ins   = 1'b0;
		do_del   = 1'b0;
		do_rot   = 1'b0;
		res_d    = '0;
		case (state_q)
			ple_pkg::BK_EXEC: begin
				if (!empty) begin
					pop        = 1'b1;
					strobe_d   = 1'b1;
					res_d.last = 1'b1;
					case (head.op)
						ple_pkg::OP_INS_FRONT, ple_pkg::OP_INS_POS,
						ple_pkg::OP_INS_END: begin
							if (full_w) begin
								res_d.status = ple_pkg::STAT_FULL;
							end else if (9'(ins_pos) > 9'(cnt_q)) begin
								res_d.status = ple_pkg::STAT_RANGE;
							end else begin
								res_d.status = ple_pkg::STAT_OK;
								do_ins       = 1'b1;
								cnt_d        = cnt_q + 1'b1;
							end
						end
						ple_pkg::OP_DEL: begin
							if (cnt_q == '0) begin
								res_d.status = ple_pkg::STAT_EMPTY;
							end else if (9'(head.position) >= 9'(cnt_q)) begin
								res_d.status = ple_pkg::STAT_RANGE;
							end else begin
								res_d.status = ple_pkg::STAT_OK;
								do_del       = 1'b1;
								cnt_d        = cnt_q - 1'b1;
							end
						end
						ple_pkg::OP_DUMP: begin
							if (cnt_q == '0) begin
								res_d.status = ple_pkg::STAT_EMPTY;
							end else begin
								// first word goes out now, the rest stream from the dump state
								res_d.status     = ple_pkg::STAT_OK;
								res_d.item_value = cell_q[0];
								do_rot           = 1'b1;
								res_d.last       = (cnt_q == CW'(1));
								if (cnt_q != CW'(1)) begin
									state_d = ple_pkg::BK_DUMP;
									idx_d   = CW'(1);
								end
							end
						end
						default: begin
							res_d.status = ple_pkg::STAT_RANGE;
						end
					endcase
				end
			end
			ple_pkg::BK_DUMP: begin
				strobe_d         = 1'b1;
				res_d.status     = ple_pkg::STAT_OK;
				res_d.item_value = cell_q[0];
				res_d.item_index = ple_pkg::POS_W'(idx_q);
				do_rot           = 1'b1;
				res_d.last       = (idx_q == cnt_q - 1'b1);
				idx_d            = idx_q + 1'b1;
				if (res_d.last) begin
					state_d = ple_pkg::BK_EXEC;
				end
			end
			default: begin
				state_d = ple_pkg::BK_EXEC;
			end
		endcase
		res_d.length = ple_pkg::POS_W'(cnt_d);
	end

	// per-cell next value: shift up, shift down or rotate within the count
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			cell_d[i] = cell_q[i];
			if (do_ins) begin
				if (ple_pkg::POS_W'(i) == ins_pos) begin
					cell_d[i] = head.value;
				end else if (ple_pkg::POS_W'(i) > ins_pos) begin
					cell_d[i] = dn_w[i];
				end
			end else if (do_del) begin
				if (ple_pkg::POS_W'(i) >= head.position) begin
					cell_d[i] = up_w[i];
				end
			end else if (do_rot) begin
				if ((CW+1)'(i) + 1'b1 < (CW+1)'(cnt_q)) begin
					cell_d[i] = up_w[i];
				end else if ((CW+1)'(i) + 1'b1 == (CW+1)'(cnt_q)) begin
					cell_d[i] = cell_q[0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			cell_q[i] <= cell_d[i];
		end
		result <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ple_pkg::BK_EXEC;
			cnt_q   <= '0;
			idx_q   <= '0;
			strobe  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
			strobe  <= strobe_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/ple_checker.sv -----
// ----------------------------------------------------------------------------
// ple_checker
// Port-level checks on the result stream of the list engine.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_checker #(
	parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
	input wire           clk,
	input wire           arst_n,
	input wire           start,
	input wire           busy,
	input ple_pkg::cmd_t cmd,
	input wire           strobe,
	input ple_pkg::res_t result
);

	logic unused_w;
	assign unused_w = start ^ busy ^ (^cmd);

	// only a dump gives more than one word, and those are all ok
	a_mid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |-> result.status == ple_pkg::STAT_OK)
		else $error("non-final word with bad status");

	// a dump streams with no gaps
	a_stream: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |=> strobe)
		else $error("gap in dump stream");

	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |=>
		result.item_index == $past(result.item_index) + 8'd1)
		else $error("dump index not consecutive");

	a_len_hold: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |=> $stable(result.length))
		else $error("length changed during dump");

	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> result.length <= ple_pkg::POS_W'(DEPTH))
		else $error("length beyond capacity");

endmodule

bind positional_list_engine_top ple_checker #(
	.DEPTH (DEPTH)
) u_ple_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.strobe (strobe),
	.result (result)
);

`default_nettype wire
